// ===== design/stq_pkg.sv =====
package stq_pkg;

  localparam int unsigned ADDR_W = 8;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEVEL_W = 8;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Smallest header length that still describes one row.
  localparam logic [DATA_W-1:0] MIN_HDR = 8'd2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUANT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_SHIFT,
    ST_END,
    ST_START,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

// ===== design/stq_if.sv =====
interface stq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [stq_pkg::ADDR_W-1:0]   table_addr;
  logic [stq_pkg::DATA_W-1:0]   table_data;
  logic [stq_pkg::VALUE_W-1:0]  value;

  modport source (output valid, op, table_addr, table_data, value, input ready);
  modport sink (input valid, op, table_addr, table_data, value, output ready);
endinterface

interface stq_out_if;
  logic                         valid;
  logic                         ready;
  logic [stq_pkg::LEVEL_W-1:0]  level_id;

  modport source (output valid, level_id, input ready);
  modport sink (input valid, level_id, output ready);
endinterface

// ===== design/stq_table.sv =====
// Threshold table: one write port, one read port with registered data.
// Addresses at or above the depth ignore writes and read back as zero.
module stq_table #(
  parameter int unsigned TABLE_DEPTH = stq_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  stq_pkg::wr_req_t           wr_i,
  input  stq_pkg::rd_req_t           rd_i,
  output logic [stq_pkg::DATA_W-1:0] rdata_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [stq_pkg::DATA_W-1:0] mem [TABLE_DEPTH];
  logic [stq_pkg::DATA_W-1:0] rdata_q;
  logic                       oor_q;
  logic                       wr_in_range;
  logic                       rd_in_range;

  assign wr_in_range = {1'b0, wr_i.addr} < 9'(TABLE_DEPTH);
  assign rd_in_range = {1'b0, rd_i.addr} < 9'(TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range) begin
      mem[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      oor_q <= !rd_in_range;
      if (rd_in_range) begin
        rdata_q <= mem[rd_i.addr[AW-1:0]];
      end
    end
  end

  assign rdata_o = oor_q ? '0 : rdata_q;

endmodule

// ===== design/segmented_table_quantizer.sv =====
// Segmented threshold-table quantizer. Write items (op 0) store one byte of the
// table and give no result. Quantize items (op 1) run on a small sequencer
// around one table read port and one shift-and-compare unit. The cycle that
// takes the item issues the header read. The sequencer then reads the header
// length, shifts the sample right (at most VALUE_BITS-8 shifts), issues the
// row end read, fetches the row end and the row start, reads and compares
// each threshold examined along the row, notes when the row runs out without
// a hit, and hands the result to the output register. A sample that saturates
// on the top row skips the row search, and a header too short to describe a
// row goes straight to the result. The pace is set by the table read port,
// which serves one address per cycle with registered data. The block is ready
// again in the cycle in which the result appears, unless the output register
// is still occupied, in which case it waits until that item is taken. The
// input is not ready while a quantize item is in progress; the output register
// lets the next item be accepted while a result still waits to be taken.
// Table entries must be written before a quantize item reads them.
module segmented_table_quantizer #(
  parameter int unsigned TABLE_DEPTH = stq_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = stq_pkg::VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stq_in_if.sink    in_i,
  stq_out_if.source out_o
);

  localparam int unsigned DW = stq_pkg::DATA_W;

  stq_pkg::state_e state_q, state_d;

  // Working registers of the sequencer.
  logic [VALUE_BITS-1:0] v_q, v_d;
  logic [DW-1:0]         shifts_q, shifts_d;
  logic [DW-1:0]         hdr_q, hdr_d;
  logic [DW-1:0]         top_q, top_d;
  logic [DW-1:0]         end_q, end_d;
  logic [DW-1:0]         pos_q, pos_d;
  logic [DW-1:0]         res_q, res_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic [stq_pkg::LEVEL_W-1:0]   level_q, level_d;

  stq_pkg::wr_req_t wr_req;
  stq_pkg::rd_req_t rd_req;
  logic [DW-1:0]    rdata;

  logic accept;
  logic wide;
  logic out_free;

  assign accept   = in_i.valid && in_i.ready;
  assign wide     = (v_q >> 8) != '0;
  assign out_free = !out_valid_q || out_o.ready;

  stq_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .wr_i   (wr_req),
    .rd_i   (rd_req),
    .rdata_o(rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      stq_pkg::ST_IDLE: begin
        if (accept && (in_i.op == stq_pkg::OP_QUANT)) begin
          state_d = stq_pkg::ST_HDR;
        end
      end
      stq_pkg::ST_HDR: begin
        state_d = (rdata < stq_pkg::MIN_HDR) ? stq_pkg::ST_DONE : stq_pkg::ST_SHIFT;
      end
      stq_pkg::ST_SHIFT: begin
        if (!(wide && (shifts_q < top_q))) begin
          state_d = stq_pkg::ST_END;
        end
      end
      stq_pkg::ST_END: begin
        state_d = wide ? stq_pkg::ST_DONE : stq_pkg::ST_START;
      end
      stq_pkg::ST_START: begin
        state_d = stq_pkg::ST_SCAN_RD;
      end
      stq_pkg::ST_SCAN_RD: begin
        state_d = (pos_q < end_q) ? stq_pkg::ST_SCAN_CHK : stq_pkg::ST_DONE;
      end
      stq_pkg::ST_SCAN_CHK: begin
        state_d = (v_q[DW-1:0] <= rdata) ? stq_pkg::ST_DONE : stq_pkg::ST_SCAN_RD;
      end
      stq_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = stq_pkg::ST_IDLE;
        end
      end
      default: state_d = stq_pkg::ST_IDLE;
    endcase
  end

  // Outputs, table requests and datapath updates.
  always_comb begin
    in_i.ready  = 1'b0;
    wr_req      = '0;
    rd_req      = '0;
    v_d         = v_q;
    shifts_d    = shifts_q;
    hdr_d       = hdr_q;
    top_d       = top_q;
    end_d       = end_q;
    pos_d       = pos_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    level_d     = level_q;

    case (state_q)
      stq_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.op == stq_pkg::OP_WRITE) begin
            wr_req.en   = 1'b1;
            wr_req.addr = in_i.table_addr;
            wr_req.data = in_i.table_data;
          end else begin
            rd_req.en = 1'b1;
            v_d       = in_i.value[VALUE_BITS-1:0];
            shifts_d  = '0;
          end
        end
      end
      stq_pkg::ST_HDR: begin
        hdr_d = rdata;
        top_d = rdata - stq_pkg::MIN_HDR;
        res_d = '0;
      end
      stq_pkg::ST_SHIFT: begin
        if (wide && (shifts_q < top_q)) begin
          v_d      = v_q >> 1;
          shifts_d = shifts_q + 8'd1;
        end else begin
          rd_req.en   = 1'b1;
          rd_req.addr = shifts_q + 8'd1;
        end
      end
      stq_pkg::ST_END: begin
        end_d = rdata;
        if (wide) begin
          // Sample too wide even for the top row: saturate to its end.
          res_d = rdata - hdr_q;
        end else begin
          rd_req.en   = 1'b1;
          rd_req.addr = shifts_q;
        end
      end
      stq_pkg::ST_START: begin
        pos_d = rdata;
      end
      stq_pkg::ST_SCAN_RD: begin
        if (pos_q < end_q) begin
          rd_req.en   = 1'b1;
          rd_req.addr = pos_q;
        end else begin
          res_d = pos_q - hdr_q;
        end
      end
      stq_pkg::ST_SCAN_CHK: begin
        if (v_q[DW-1:0] <= rdata) begin
          res_d = pos_q - hdr_q;
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
      stq_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          level_d     = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    shifts_q <= shifts_d;
    hdr_q    <= hdr_d;
    top_q    <= top_d;
    end_q    <= end_d;
    pos_q    <= pos_d;
    res_q    <= res_d;
    level_q  <= level_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.level_id = level_q;

  // The shift count never passes the top row.
  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stq_pkg::ST_SHIFT) |-> (shifts_q <= top_q))
    else $error("shift count beyond top row");

  // A threshold is only examined inside the row.
  a_scan_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stq_pkg::ST_SCAN_CHK) |-> (pos_q < end_q))
    else $error("threshold read outside the row");

  // The row search only starts once the sample fits in a byte.
  a_search_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stq_pkg::ST_START || state_q == stq_pkg::ST_SCAN_CHK) |-> !wide)
    else $error("row search with a sample wider than a byte");

  // A finished result is not dropped while the output register is occupied.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stq_pkg::ST_DONE && out_valid_q && !out_o.ready)
      |=> (state_q == stq_pkg::ST_DONE) && $stable(res_q))
    else $error("result lost while output stalled");

endmodule
